@@ rtl/core/rgcl_pkg.sv @@
// shared types, register codes and constants of the reverse guard command limiter
`default_nettype none

package rgcl_pkg;

    // register indexes of the configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VELOCITY    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_STEER_ANGLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEER_RATIO     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_HOLD_TICKS = 3'd3;

    localparam int unsigned CFG_DATA_W = 16;

    // steering conversion: angle = (ratio * rate * STEER_SCALE) >>> STEER_SHIFT
    localparam int unsigned STEER_SCALE   = 5730;
    localparam int unsigned STEER_SHIFT   = 20;
    localparam int unsigned SCALE_W       = 29;    // 65535 * 5730 fits in 29 bits
    localparam int unsigned PRODUCT_W     = SCALE_W + 1 + 16;

    // reverse detection
    localparam logic [1:0] REVERSE_CONFIRM = 2'd2;
    localparam logic [1:0] REVERSE_MAX     = 2'd3;

    // reset values of the registers
    localparam logic [14:0] MAX_VELOCITY_RST    = 15'd5000;
    localparam logic [14:0] MAX_STEER_ANGLE_RST = 15'd3000;
    localparam logic [15:0] STEER_RATIO_RST     = 16'd5120;
    localparam logic [7:0]  STOP_HOLD_TICKS_RST = 8'd20;

    typedef struct packed {
        logic [14:0]        max_velocity;
        logic [14:0]        max_steer_angle;
        logic [SCALE_W-1:0] steer_scale;      // steer ratio premultiplied by STEER_SCALE
        logic [7:0]         stop_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic hold;      // transaction is forced to zero by the stop hold
    } guard_status_t;

    function automatic logic [SCALE_W-1:0] scale_ratio(input logic [15:0] ratio);
        logic [SCALE_W-1:0] scale_k;
        scale_k = SCALE_W'(STEER_SCALE);
        return SCALE_W'({13'd0, ratio} * scale_k);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/reverse_guard_command_limiter_core.sv @@
// top level of the reverse guard command limiter
`default_nettype none

// Conditions a stream of motion commands, one result transaction per input
// transaction. Velocity is capped above at max_velocity (never limited below);
// the yaw rate becomes a steering angle in centidegrees,
// (steer_ratio * angular_rate * 5730) >>> 20, clamped to +/- max_steer_angle.
// Two consecutive negative velocities start a stop hold that forces zero
// outputs (hold_active high) for stop_hold_ticks transactions; the next one
// releases the hold and passes normally. The block is a two-register pipeline:
// an input register and a result register with one 30x16 multiply, the clamps
// and the hold counters between them. It takes one transaction per cycle
// while the result register is not stalled by out_ready. While a result
// waits, the input register still takes one transaction, then in_ready
// stays low until the result is taken. Registers are written through
// cfg_we / cfg_index / cfg_wdata only while the block is idle, a rule for
// the user that the block itself does not enforce; the steer ratio is
// stored premultiplied by 5730, computed at write time.
module reverse_guard_command_limiter_core
    import rgcl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    // command input
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [15:0]     linear_velocity,
    input  wire logic signed [15:0]     angular_rate,
    // conditioned output
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [15:0]          velocity_out,
    output logic signed [15:0]          steering_out,
    output logic                        hold_active
);

    cfg_t cfg_reg;

    // input register
    logic               s1_valid_reg;
    logic signed [15:0] s1_vel_reg;
    logic signed [15:0] s1_rate_reg;

    // result register
    logic               out_valid_reg;
    logic signed [15:0] velocity_out_reg;
    logic signed [15:0] steering_out_reg;
    logic               hold_active_reg;

    logic signed [15:0] velocity_out_next;
    logic signed [15:0] steering_out_next;
    logic signed [15:0] vel_capped;
    logic signed [15:0] steer_angle;
    logic               s2_load;
    guard_status_t      guard_status;

    // the result register takes a transaction when empty or being drained
    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_velocity    <= MAX_VELOCITY_RST;
            cfg_reg.max_steer_angle <= MAX_STEER_ANGLE_RST;
            cfg_reg.steer_scale     <= scale_ratio(STEER_RATIO_RST);
            cfg_reg.stop_hold_ticks <= STOP_HOLD_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_VELOCITY:    cfg_reg.max_velocity    <= cfg_wdata[14:0];
                REG_MAX_STEER_ANGLE: cfg_reg.max_steer_angle <= cfg_wdata[14:0];
                REG_STEER_RATIO:     cfg_reg.steer_scale     <= scale_ratio(cfg_wdata);
                REG_STOP_HOLD_TICKS: cfg_reg.stop_hold_ticks <= cfg_wdata[7:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_vel_reg  <= linear_velocity;
            s1_rate_reg <= angular_rate;
        end
        if (s2_load)
        begin
            velocity_out_reg <= velocity_out_next;
            steering_out_reg <= steering_out_next;
            hold_active_reg  <= guard_status.hold;
        end
    end

    // velocity cap from above only; the cap never changes the sign
    always_comb
    begin
        if (s1_vel_reg > $signed({1'b0, cfg_reg.max_velocity}))
        begin
            vel_capped = $signed({1'b0, cfg_reg.max_velocity});
        end
        else
        begin
            vel_capped = s1_vel_reg;
        end
    end

    rgcl_steer u_steer (
        .angular_rate    (s1_rate_reg),
        .steer_scale     (cfg_reg.steer_scale),
        .max_steer_angle (cfg_reg.max_steer_angle),
        .steering        (steer_angle)
    );

    // hold state advances once per transaction moved into the result register
    rgcl_guard u_guard (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (s2_load),
        .vel_neg         (s1_vel_reg[15]),
        .stop_hold_ticks (cfg_reg.stop_hold_ticks),
        .status          (guard_status)
    );

    // held transactions are forced to zero
    always_comb
    begin
        if (guard_status.hold)
        begin
            velocity_out_next = 16'sd0;
            steering_out_next = 16'sd0;
        end
        else
        begin
            velocity_out_next = vel_capped;
            steering_out_next = steer_angle;
        end
    end

    assign out_valid    = out_valid_reg;
    assign velocity_out = velocity_out_reg;
    assign steering_out = steering_out_reg;
    assign hold_active  = hold_active_reg;

    a_held_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_active |-> velocity_out == 16'sd0 && steering_out == 16'sd0)
        else $error("held transaction carries nonzero command");

    a_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !s2_load)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/core/rgcl_steer.sv @@
// yaw rate to steering angle conversion with symmetric clamp
`default_nettype none

module rgcl_steer
    import rgcl_pkg::*;
(
    input  wire logic signed [15:0]        angular_rate,
    input  wire logic        [SCALE_W-1:0] steer_scale,
    input  wire logic        [14:0]        max_steer_angle,
    output logic signed      [15:0]        steering
);

    logic signed [PRODUCT_W-1:0] product;
    logic signed [PRODUCT_W-1:0] shifted;
    logic signed [PRODUCT_W-1:0] lim_pos;
    logic signed [PRODUCT_W-1:0] lim_neg;

    always_comb
    begin
        // one 30x16 signed multiply
        product = PRODUCT_W'($signed({1'b0, steer_scale}) * angular_rate);
        // arithmetic shift is a floor
        shifted = product >>> STEER_SHIFT;
        lim_pos = $signed({{(PRODUCT_W-15){1'b0}}, max_steer_angle});
        lim_neg = -lim_pos;
        if (shifted > lim_pos)
        begin
            steering = lim_pos[15:0];
        end
        else if (shifted < lim_neg)
        begin
            steering = lim_neg[15:0];
        end
        else
        begin
            steering = shifted[15:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rgcl_guard.sv @@
// reverse detection and stop hold counters
`default_nettype none

module rgcl_guard
    import rgcl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          vel_neg,
    input  wire logic [7:0]    stop_hold_ticks,
    output guard_status_t      status
);

    logic [1:0] reverse_count_reg;
    logic [1:0] reverse_count_next;
    logic [7:0] hold_count_reg;
    logic [7:0] hold_count_next;
    logic       holding_reg;
    logic       holding_next;
    logic [1:0] reverse_bumped;
    logic       holding_set;

    always_comb
    begin
        if (!vel_neg)
        begin
            reverse_bumped = 2'd0;
        end
        else if (reverse_count_reg == REVERSE_MAX)
        begin
            reverse_bumped = REVERSE_MAX;
        end
        else
        begin
            reverse_bumped = reverse_count_reg + 2'd1;
        end
        holding_set = holding_reg || (reverse_bumped >= REVERSE_CONFIRM);

        status.hold        = 1'b0;
        reverse_count_next = reverse_bumped;
        hold_count_next    = hold_count_reg;
        holding_next       = holding_set;
        if (holding_set && (hold_count_reg < stop_hold_ticks))
        begin
            status.hold     = 1'b1;
            hold_count_next = hold_count_reg + 8'd1;
        end
        else if (hold_count_reg >= stop_hold_ticks)
        begin
            // release: that item passes normally
            holding_next       = 1'b0;
            hold_count_next    = 8'd0;
            reverse_count_next = REVERSE_CONFIRM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_count_reg <= 2'd0;
            hold_count_reg    <= 8'd0;
            holding_reg       <= 1'b0;
        end
        else if (advance)
        begin
            reverse_count_reg <= reverse_count_next;
            hold_count_reg    <= hold_count_next;
            holding_reg       <= holding_next;
        end
    end

    a_hold_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && status.hold |=> hold_count_reg == $past(hold_count_reg) + 8'd1)
        else $error("hold counter did not step on a held transaction");

    a_release_presets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !status.hold && (hold_count_reg >= stop_hold_ticks)
        |=> hold_count_reg == 8'd0 && reverse_count_reg == REVERSE_CONFIRM && !holding_reg)
        else $error("release did not clear the hold");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !holding_reg |-> hold_count_reg == 8'd0)
        else $error("hold counter nonzero outside a hold");

    a_hold_needs_holding: assert property (@(posedge clk) disable iff (!rst_n)
        status.hold |-> holding_next && (hold_count_reg < stop_hold_ticks))
        else $error("hold flagged without a hold in force");

endmodule

`default_nettype wire
